// ----- rtl/ssht_pkg.sv -----
// ----------------------------------------------------------------------------
// ssht_pkg
// Shared constants, widths and status types for the swept sphere hit unit.
// ----------------------------------------------------------------------------
package ssht_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int MID_DEPTH       = 4;
   localparam int OUT_DEPTH       = 2;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   // Width of one classified item between the front and the back.
   function automatic int front_width(input int cw);
      return 3 * cw + 3 * (cw + 1) + (cw - 1) + 2 * (2 * cw + 2) + (2 * cw + 3);
   endfunction

   // Width of one result beat.
   function automatic int result_width(input int cw, input int fb);
      return 1 + (fb + 1) + 3 * cw;
   endfunction

endpackage

// ----- rtl/swept_sphere_hit_time.sv -----
// ----------------------------------------------------------------------------
// swept_sphere_hit_time
// First contact time and point of a sphere moving along a segment against a
// static sphere, in signed fixed point.
// ----------------------------------------------------------------------------
// Queries enter through a queue-like port: a beat is taken when push is high
// and full is low. Results leave the same way: the oldest result sits on the
// rsp_ ports while empty is low and is taken when pop is high.
// One result beat is produced for every query beat, in order.
// A new query can be taken every cycle while full is low. The back has
// QW square-root stages, where QW = 2*COORD_WIDTH + 2 + FRAC_BITS, and F + 1
// divider stages. The square-root pipeline sets the latency.
// A two-stage front computes vectors and squared lengths and feeds a short
// queue; the back pipeline drains it while the output queue has room.
// When the receiver stops popping, the output queue fills, the back stalls,
// the middle queue fills, and full rises; nothing is lost.
// Reset empties both queues and clears every stage valid bit.
// ----------------------------------------------------------------------------
module swept_sphere_hit_time #(
   parameter int COORD_WIDTH = ssht_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = ssht_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [COORD_WIDTH-1:0] req_start_x,
   input  logic [COORD_WIDTH-1:0] req_start_y,
   input  logic [COORD_WIDTH-1:0] req_start_z,
   input  logic [COORD_WIDTH-1:0] req_end_x,
   input  logic [COORD_WIDTH-1:0] req_end_y,
   input  logic [COORD_WIDTH-1:0] req_end_z,
   input  logic [COORD_WIDTH-1:0] req_center_x,
   input  logic [COORD_WIDTH-1:0] req_center_y,
   input  logic [COORD_WIDTH-1:0] req_center_z,
   input  logic [COORD_WIDTH-2:0] req_moving_radius,
   input  logic [COORD_WIDTH-2:0] req_static_radius,
   output logic                   empty,
   input  logic                   pop,
   output logic                   rsp_hit,
   output logic [FRAC_BITS:0]     rsp_hit_time,
   output logic [COORD_WIDTH-1:0] rsp_point_x,
   output logic [COORD_WIDTH-1:0] rsp_point_y,
   output logic [COORD_WIDTH-1:0] rsp_point_z
);
   import ssht_pkg::*;

   localparam int FW = front_width(COORD_WIDTH);
   localparam int OW = result_width(COORD_WIDTH, FRAC_BITS);

   logic          front_ready, front_push, back_pop, back_push;
   logic [FW-1:0] front_data, mid_data;
   logic [OW-1:0] back_data, out_data;
   q_status_type  mid_status, out_status;

   assign full = !front_ready;

   ssht_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (push),
      .in_ready     (front_ready),
      .start_pos    ({req_start_z, req_start_y, req_start_x}),
      .end_pos      ({req_end_z, req_end_y, req_end_x}),
      .center_pos   ({req_center_z, req_center_y, req_center_x}),
      .moving_radius(req_moving_radius),
      .static_radius(req_static_radius),
      .out_full     (mid_status.full),
      .out_push     (front_push),
      .out_data     (front_data)
   );

   ssht_queue #(
      .WIDTH(FW),
      .DEPTH(MID_DEPTH)
   ) u_mid_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_data(front_data),
      .pop      (back_pop),
      .pop_data (mid_data),
      .status   (mid_status)
   );

   ssht_back #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .in_valid(!mid_status.empty),
      .in_data (mid_data),
      .in_pop  (back_pop),
      .out_full(out_status.full),
      .out_push(back_push),
      .out_data(back_data)
   );

   ssht_queue #(
      .WIDTH(OW),
      .DEPTH(OUT_DEPTH)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (back_push),
      .push_data(back_data),
      .pop      (pop),
      .pop_data (out_data),
      .status   (out_status)
   );

   assign empty = out_status.empty;
   assign {rsp_hit, rsp_hit_time, rsp_point_z, rsp_point_y, rsp_point_x} = out_data;

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      back_push |-> !out_status.full)
      else $error("result pushed into a full output queue");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_hit) |-> (rsp_hit_time == '0 && rsp_point_x == '0
         && rsp_point_y == '0 && rsp_point_z == '0))
      else $error("miss beat carries nonzero time or point");

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_hit) |-> (rsp_hit_time <= ((FRAC_BITS + 1)'(1) << FRAC_BITS)))
      else $error("hit time beyond the end of the motion");

   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      (front_push == 1'b0 && mid_status.full) |=> !back_push || !out_status.full)
      else $error("back section pushed while output queue was full");
`endif

endmodule

// ----- rtl/ssht_queue.sv -----
// ----------------------------------------------------------------------------
// ssht_queue
// Small first-in first-out buffer that decouples two pipeline sections.
// ----------------------------------------------------------------------------
module ssht_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      pop_data,
   output ssht_pkg::q_status_type status
);
   import ssht_pkg::*;

   localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNW-1:0]   count_ff;
   logic             do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNW'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/ssht_front.sv -----
// ----------------------------------------------------------------------------
// ssht_front
// Takes queries, forms the motion and offset vectors, the saturated contact
// radius, the squared lengths and the dot product.
// ----------------------------------------------------------------------------
module ssht_front #(
   parameter int COORD_WIDTH = ssht_pkg::COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [2:0][COORD_WIDTH-1:0] start_pos,
   input  logic [2:0][COORD_WIDTH-1:0] end_pos,
   input  logic [2:0][COORD_WIDTH-1:0] center_pos,
   input  logic [COORD_WIDTH-2:0] moving_radius,
   input  logic [COORD_WIDTH-2:0] static_radius,
   input  logic                   out_full,
   output logic                   out_push,
   output logic [ssht_pkg::front_width(COORD_WIDTH)-1:0] out_data
);
   import ssht_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int LW = 2 * CW + 2;
   localparam int PRW = 2 * CW + 2;

   logic                 adv;
   logic                 s1_valid_ff, s2_valid_ff;
   logic [2:0][CW-1:0]   s1_st_ff, s2_st_ff;
   logic [2:0][CW:0]     s1_v_ff, s1_d_ff, s2_v_ff;
   logic [2:0][CW:0]     v_in, d_in;
   logic [CW-2:0]        s1_rad_ff, s2_rad_ff, rad_in;
   logic [CW-1:0]        rad_sum;
   logic [2:0][PRW-1:0]  sqv, sqd, dot;
   logic [LW-1:0]        s2_l2_ff, s2_dd_ff;
   logic [LW:0]          s2_dvs_ff;

   assign adv      = !s2_valid_ff || !out_full;
   assign in_ready = adv;
   assign out_push = s2_valid_ff && !out_full;
   assign out_data = {s2_st_ff, s2_v_ff, s2_rad_ff, s2_l2_ff, s2_dd_ff, s2_dvs_ff};

   for (genvar k = 0; k < 3; k++) begin : g_axis
      assign v_in[k] = {end_pos[k][CW-1], end_pos[k]} - {start_pos[k][CW-1], start_pos[k]};
      assign d_in[k] = {center_pos[k][CW-1], center_pos[k]}
                     - {start_pos[k][CW-1], start_pos[k]};
      assign sqv[k]  = PRW'($signed(s1_v_ff[k]) * $signed(s1_v_ff[k]));
      assign sqd[k]  = PRW'($signed(s1_d_ff[k]) * $signed(s1_d_ff[k]));
      assign dot[k]  = PRW'($signed(s1_v_ff[k]) * $signed(s1_d_ff[k]));
   end

   assign rad_sum = {1'b0, moving_radius} + {1'b0, static_radius};
   assign rad_in  = rad_sum[CW-1] ? '1 : rad_sum[CW-2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_st_ff  <= start_pos;
         s1_v_ff   <= v_in;
         s1_d_ff   <= d_in;
         s1_rad_ff <= rad_in;
         s2_st_ff  <= s1_st_ff;
         s2_v_ff   <= s1_v_ff;
         s2_rad_ff <= s1_rad_ff;
         s2_l2_ff  <= LW'(sqv[0]) + LW'(sqv[1]) + LW'(sqv[2]);
         s2_dd_ff  <= LW'(sqd[0]) + LW'(sqd[1]) + LW'(sqd[2]);
         s2_dvs_ff <= (LW + 1)'($signed(dot[0])) + (LW + 1)'($signed(dot[1]))
                    + (LW + 1)'($signed(dot[2]));
      end
   end

endmodule

// ----- rtl/ssht_back.sv -----
// ----------------------------------------------------------------------------
// ssht_back
// Pipelined discriminant, digit-serial square root, restoring divider and
// contact point for classified items. The whole section advances together.
// ----------------------------------------------------------------------------
module ssht_back #(
   parameter int COORD_WIDTH = ssht_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = ssht_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [ssht_pkg::front_width(COORD_WIDTH)-1:0] in_data,
   output logic in_pop,
   input  logic out_full,
   output logic out_push,
   output logic [ssht_pkg::result_width(COORD_WIDTH, FRAC_BITS)-1:0] out_data
);
   import ssht_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int LW  = 2 * CW + 2;
   localparam int DW  = 2 * LW;
   localparam int H   = (LW + 1) / 2;
   localparam int XW  = DW + 2 * F;
   localparam int QW  = XW / 2;
   localparam int NW  = LW + F;
   localparam int HTW = F + 1;
   localparam int RW  = QW + 2;
   localparam int PW  = CW + 1 + HTW + 1;

   typedef struct packed {
      logic               miss;
      logic [2:0][CW-1:0] st;
      logic [2:0][CW:0]   v;
      logic [LW-1:0]      dv;
      logic [LW-1:0]      l2;
   } carry_type;

   logic adv;
   logic [2:0][CW-1:0] i_st;
   logic [2:0][CW:0]   i_v;
   logic [CW-2:0]      i_rad;
   logic [LW-1:0]      i_l2, i_dd;
   logic [LW:0]        i_dvs;

   assign adv      = !out_full;
   assign in_pop   = adv && in_valid;
   assign {i_st, i_v, i_rad, i_l2, i_dd, i_dvs} = in_data;

   // Discriminant section.
   logic          b0_valid_ff, b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   carry_type     b0_c_ff, b1_c_ff, b2_c_ff, b3_c_ff, b4_c_ff;
   logic [2*CW-3:0] b0_r2_ff;
   logic [LW-1:0] b0_dd_ff, b1_e_ff;
   logic [3:0][2*H-1:0] b2_pa_ff, b2_pb_ff;
   logic [DW-1:0] b3_a_ff, b3_b_ff, b4_d_ff;
   logic [LW-H-1:0] dv_hi, l2_hi, e_hi;
   logic [H-1:0]    dv_lo, l2_lo, e_lo;
   carry_type     b0_c_in, b1_c_in, b4_c_in;

   assign b0_c_in.miss = (i_l2 == '0) || i_dvs[LW];
   assign b0_c_in.st   = i_st;
   assign b0_c_in.v    = i_v;
   assign b0_c_in.dv   = i_dvs[LW-1:0];
   assign b0_c_in.l2   = i_l2;

   assign {dv_hi, dv_lo} = b1_c_ff.dv;
   assign {l2_hi, l2_lo} = b1_c_ff.l2;
   assign {e_hi, e_lo}   = b1_e_ff;

   always_comb begin
      b1_c_in      = b0_c_ff;
      b1_c_in.miss = b0_c_ff.miss || (b0_dd_ff < LW'(b0_r2_ff));
      b4_c_in      = b3_c_ff;
      b4_c_in.miss = b3_c_ff.miss || (b3_a_ff < b3_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else if (adv) begin
         b0_valid_ff <= in_valid;
         b1_valid_ff <= b0_valid_ff;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b0_c_ff  <= b0_c_in;
         b0_r2_ff <= i_rad * i_rad;
         b0_dd_ff <= i_dd;

         b1_c_ff <= b1_c_in;
         b1_e_ff <= b0_dd_ff - LW'(b0_r2_ff);

         b2_c_ff     <= b1_c_ff;
         b2_pa_ff[0] <= (2 * H)'(dv_lo * dv_lo);
         b2_pa_ff[1] <= (2 * H)'(dv_hi * dv_lo);
         b2_pa_ff[2] <= (2 * H)'(dv_lo * dv_hi);
         b2_pa_ff[3] <= (2 * H)'(dv_hi * dv_hi);
         b2_pb_ff[0] <= (2 * H)'(l2_lo * e_lo);
         b2_pb_ff[1] <= (2 * H)'(l2_hi * e_lo);
         b2_pb_ff[2] <= (2 * H)'(l2_lo * e_hi);
         b2_pb_ff[3] <= (2 * H)'(l2_hi * e_hi);

         b3_c_ff <= b2_c_ff;
         b3_a_ff <= DW'(b2_pa_ff[0]) + (DW'(b2_pa_ff[1]) << H) + (DW'(b2_pa_ff[2]) << H)
                  + (DW'(b2_pa_ff[3]) << (2 * H));
         b3_b_ff <= DW'(b2_pb_ff[0]) + (DW'(b2_pb_ff[1]) << H) + (DW'(b2_pb_ff[2]) << H)
                  + (DW'(b2_pb_ff[3]) << (2 * H));

         b4_c_ff <= b4_c_in;
         b4_d_ff <= b3_a_ff - b3_b_ff;
      end
   end

   // Square root, one result bit per stage.
   logic      sq_valid_ff [QW+1];
   carry_type sq_c_ff     [QW+1];
   logic [XW-1:0] sq_x_ff    [QW+1];
   logic [RW-1:0] sq_rem_ff  [QW+1];
   logic [QW-1:0] sq_root_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_valid_ff[0] <= b4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_c_ff[0]    <= b4_c_ff;
         sq_x_ff[0]    <= {b4_d_ff, {(2 * F){1'b0}}};
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_sqrt
      logic [RW+1:0] rem_sh, trial;
      logic          take;
      assign rem_sh = {sq_rem_ff[j], sq_x_ff[j][XW-1 -: 2]};
      assign trial  = (RW + 2)'({sq_root_ff[j], 2'b01});
      assign take   = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[j+1] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[j+1] <= sq_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_c_ff[j+1]    <= sq_c_ff[j];
            sq_x_ff[j+1]    <= sq_x_ff[j] << 2;
            sq_rem_ff[j+1]  <= take ? RW'(rem_sh - trial) : RW'(rem_sh);
            sq_root_ff[j+1] <= {sq_root_ff[j][QW-2:0], take};
         end
      end
   end

   // Numerator and the test for contact after the end of the motion.
   logic          c_valid_ff;
   carry_type     c_c_ff, c_c_in;
   logic [NW-1:0] c_num_ff;
   logic [NW-1:0] late_lhs, q_root;
   logic          late;

   assign q_root   = NW'(sq_root_ff[QW]);
   assign late_lhs = {sq_c_ff[QW].dv - sq_c_ff[QW].l2, {F{1'b0}}};
   assign late     = (sq_c_ff[QW].dv > sq_c_ff[QW].l2) && (late_lhs > q_root);

   always_comb begin
      c_c_in      = sq_c_ff[QW];
      c_c_in.miss = sq_c_ff[QW].miss || late;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= sq_valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_c_ff   <= c_c_in;
         c_num_ff <= {sq_c_ff[QW].dv, {F{1'b0}}} - q_root;
      end
   end

   // Restoring divider, one quotient bit per stage.
   logic           dq_valid_ff [HTW+1];
   carry_type      dq_c_ff     [HTW+1];
   logic [NW-1:0]  dq_rem_ff   [HTW+1];
   logic [HTW-1:0] dq_quo_ff   [HTW+1];

   always_comb begin
      dq_valid_ff[0] = c_valid_ff;
      dq_c_ff[0]     = c_c_ff;
      dq_rem_ff[0]   = c_num_ff;
      dq_quo_ff[0]   = '0;
   end

   for (genvar i = 0; i < HTW; i++) begin : g_div
      localparam int BIT = HTW - 1 - i;
      logic [NW-1:0] trial;
      logic          take;
      assign trial = NW'(dq_c_ff[i].l2) << BIT;
      assign take  = (dq_rem_ff[i] >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            dq_valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            dq_valid_ff[i+1] <= dq_valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dq_c_ff[i+1]   <= dq_c_ff[i];
            dq_rem_ff[i+1] <= take ? dq_rem_ff[i] - trial : dq_rem_ff[i];
            dq_quo_ff[i+1] <= dq_quo_ff[i] | (take ? (HTW'(1) << BIT) : '0);
         end
      end
   end

   // Contact point and result beat.
   logic                fin_valid_ff;
   logic                fin_hit_ff;
   logic [HTW-1:0]      fin_ht_ff;
   logic [2:0][CW-1:0]  fin_pt_ff;
   logic [2:0][CW-1:0]  pt_in;
   logic [2:0][PW-1:0]  prod;
   carry_type           dq_last;

   assign dq_last = dq_c_ff[HTW];

   for (genvar k = 0; k < 3; k++) begin : g_point
      assign prod[k]  = PW'($signed(dq_last.v[k]) * $signed({1'b0, dq_quo_ff[HTW]}));
      assign pt_in[k] = dq_last.st[k] + prod[k][CW+F-1:F];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= dq_valid_ff[HTW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_hit_ff <= !dq_last.miss;
         fin_ht_ff  <= dq_last.miss ? '0 : dq_quo_ff[HTW];
         fin_pt_ff  <= dq_last.miss ? '0 : pt_in;
      end
   end

   assign out_push = fin_valid_ff && adv;
   assign out_data = {fin_hit_ff, fin_ht_ff, fin_pt_ff};

endmodule
